FILE: src/gbp_pkg.sv
// Shared constants, codes and types for the gshare branch predictor.
// No dependencies; used by every module in src.
package gbp_pkg;

  // Width of branch PCs and of every instruction address on the ports
  localparam int PC_BITS   = 10;
  localparam int ADDR_BITS = 10;
  localparam int CTR_BITS  = 2;

  // Default sizes handed to the top level
  localparam int INDEX_BITS_DEF    = 10;
  localparam int PENDING_DEPTH_DEF = 8;

  // Counter stored as value + 1: 0..3 stands for -1..2
  localparam logic [CTR_BITS-1:0] CTR_MIN   = 2'd0;
  localparam logic [CTR_BITS-1:0] CTR_INIT  = 2'd1;
  localparam logic [CTR_BITS-1:0] CTR_TAKEN = 2'd2;
  localparam logic [CTR_BITS-1:0] CTR_MAX   = 2'd3;

  // Item kinds
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_LOOKUP = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  // Control from the sequencer to the in-flight queue
  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } pend_ctl_t;

  // Queue occupancy flags back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } pend_sts_t;

endpackage

FILE: src/gbp_btb.sv
// Branch target buffer: one synchronous memory of valid bit and target per PC.
// Depends on gbp_pkg for the PC and address widths.
module gbp_btb (
  input  logic                           clk,
  input  logic                           we,
  input  logic [gbp_pkg::PC_BITS-1:0]    waddr,
  input  logic                           wvalid,
  input  logic [gbp_pkg::ADDR_BITS-1:0]  wtarget,
  input  logic                           re,
  input  logic [gbp_pkg::PC_BITS-1:0]    raddr,
  output logic                           rvalid,
  output logic [gbp_pkg::ADDR_BITS-1:0]  rtarget
);

  localparam int ENTRIES = 1 << gbp_pkg::PC_BITS;

  logic [gbp_pkg::ADDR_BITS:0] mem [ENTRIES];
  logic [gbp_pkg::ADDR_BITS:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalid, wtarget};
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rvalid  = rdata_r[gbp_pkg::ADDR_BITS];
  assign rtarget = rdata_r[gbp_pkg::ADDR_BITS-1:0];

endmodule

FILE: src/gbp_pht.sv
// Pattern history table: synchronous memory of 2-bit saturating counters.
// Depends on gbp_pkg for the counter width.
module gbp_pht #(
  parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [INDEX_BITS-1:0]         waddr,
  input  logic [gbp_pkg::CTR_BITS-1:0]  wdata,
  input  logic                          re,
  input  logic [INDEX_BITS-1:0]         raddr,
  output logic [gbp_pkg::CTR_BITS-1:0]  rdata
);

  localparam int ENTRIES = 1 << INDEX_BITS;

  logic [gbp_pkg::CTR_BITS-1:0] mem [ENTRIES];
  logic [gbp_pkg::CTR_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/gbp_pend.sv
// In-flight queue of table index and predicted address per outstanding predict.
// Depends on gbp_pkg for the address width and the control/status structs.
module gbp_pend #(
  parameter int INDEX_BITS    = gbp_pkg::INDEX_BITS_DEF,
  parameter int PENDING_DEPTH = gbp_pkg::PENDING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gbp_pkg::pend_ctl_t             ctl,
  input  logic [INDEX_BITS-1:0]          widx,
  input  logic [gbp_pkg::ADDR_BITS-1:0]  wpred,
  output logic [INDEX_BITS-1:0]          ridx,
  output logic [gbp_pkg::ADDR_BITS-1:0]  rpred,
  output gbp_pkg::pend_sts_t             sts
);

  localparam int PTR_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int ENT_W  = INDEX_BITS + gbp_pkg::ADDR_BITS;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PENDING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PENDING_DEPTH);

  logic [ENT_W-1:0] mem [PENDING_DEPTH];
  logic [ENT_W-1:0] rdata_r;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= {widx, wpred};
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  assign ridx      = rdata_r[ENT_W-1:gbp_pkg::ADDR_BITS];
  assign rpred     = rdata_r[gbp_pkg::ADDR_BITS-1:0];
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_FULL);

endmodule

FILE: src/gshare_branch_predictor_core.sv
// Top level of the gshare branch predictor with branch target buffer.
// Depends on gbp_pkg, gbp_btb, gbp_pht and gbp_pend.
//
// Input channel (in_*): one item per transfer, either a predict request
// (in_kind 0) or a branch resolution (in_kind 1). Result channel (out_*):
// exactly one result per accepted item, in order.
// An item moves through the transfer, lookup and update states: the transfer
// cycle reads the target buffer and the head of the in-flight queue, the
// lookup state reads the counter table at the gshare index, and the update
// state trains, writes back and loads the output register. in_stall stays
// high until the update completes, so a new item is taken only once the
// previous one is through. out_valid comes from that output register.
// After reset a clearing pass walks every target buffer and counter table
// address, invalidating the target buffer and setting every counter to 0;
// in_stall stays high throughout.
// When out_stall holds a result, the next item is still accepted and looked
// up, but it waits in its update cycle until the output register frees.
module gshare_branch_predictor_core #(
  parameter int INDEX_BITS    = gbp_pkg::INDEX_BITS_DEF,
  parameter int PENDING_DEPTH = gbp_pkg::PENDING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [gbp_pkg::PC_BITS-1:0]    in_branch_pc,
  input  logic [gbp_pkg::ADDR_BITS-1:0]  in_target_addr,
  input  logic [gbp_pkg::ADDR_BITS-1:0]  in_fallthrough_addr,
  input  logic [gbp_pkg::ADDR_BITS-1:0]  in_actual_target,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_btb_hit,
  output logic                           out_predict_taken,
  output logic [gbp_pkg::ADDR_BITS-1:0]  out_predicted_addr,
  output logic                           out_mispredict,
  output logic [gbp_pkg::ADDR_BITS-1:0]  out_redirect_addr,
  output logic [1:0]                     out_status
);

  localparam int CLR_BITS =
    (INDEX_BITS > gbp_pkg::PC_BITS) ? INDEX_BITS : gbp_pkg::PC_BITS;
  localparam int AW = gbp_pkg::ADDR_BITS;
  localparam int CW = gbp_pkg::CTR_BITS;

  gbp_pkg::state_t state_r, state_nxt;
  logic [CLR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [INDEX_BITS-1:0] ghr_r, ghr_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;

  // Latched item fields
  logic                      kind_r;
  logic [gbp_pkg::PC_BITS-1:0] pc_r;
  logic [AW-1:0]             tgt_r, fall_r, actual_r;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_taken_r, out_misp_r;
  logic [AW-1:0] out_paddr_r, out_redir_r;
  logic [1:0]    out_status_r;

  // Memory ports
  logic                        btb_we, btb_wvalid, btb_rvalid;
  logic [gbp_pkg::PC_BITS-1:0] btb_waddr;
  logic [AW-1:0]               btb_wtarget, btb_rtarget;
  logic                        pht_we, pht_re;
  logic [INDEX_BITS-1:0]       pht_waddr, pht_raddr;
  logic [CW-1:0]               pht_wdata, pht_rdata;
  gbp_pkg::pend_ctl_t          pend_ctl;
  gbp_pkg::pend_sts_t          pend_sts;
  logic [INDEX_BITS-1:0]       pend_ridx;
  logic [AW-1:0]               pend_rpred;

  // Update-cycle terms
  logic          accept, out_free, fire, clearing, clr_last;
  logic          is_pred, pred_hit, res_hit, taken, up, train;
  logic [AW-1:0] paddr;
  logic [CW-1:0] ctr_trained;
  logic [1:0]    status;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != gbp_pkg::S_IDLE);
  assign clearing = (state_r == gbp_pkg::S_CLEAR);
  assign clr_last = (clr_cnt_r == '1);
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == gbp_pkg::S_UPDATE) && out_free;

  assign is_pred  = (kind_r == gbp_pkg::KIND_PREDICT);
  assign pred_hit = is_pred && btb_rvalid;
  assign res_hit  = !is_pred && btb_rvalid;
  assign taken    = pred_hit && (pht_rdata >= gbp_pkg::CTR_TAKEN);
  assign paddr    = pred_hit ? (taken ? btb_rtarget : fall_r) : '0;
  // A correct prediction off the fallthrough, or a wrong one on it, was taken
  assign up       = (pend_rpred == actual_r) ? (pend_rpred != fall_r)
                                             : (pend_rpred == fall_r);
  assign train    = fire && res_hit && !pend_sts.empty;

  always_comb begin
    if (up) begin
      ctr_trained = (pht_rdata == gbp_pkg::CTR_MAX) ? pht_rdata : pht_rdata + 1'b1;
    end else begin
      ctr_trained = (pht_rdata == gbp_pkg::CTR_MIN) ? pht_rdata : pht_rdata - 1'b1;
    end
  end

  always_comb begin
    priority if (pred_hit && pend_sts.full) begin
      status = gbp_pkg::ST_OVERFLOW;
    end else if (res_hit && pend_sts.empty) begin
      status = gbp_pkg::ST_UNDERFLOW;
    end else begin
      status = gbp_pkg::ST_OK;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      gbp_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          state_nxt = gbp_pkg::S_IDLE;
        end
      end
      gbp_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = gbp_pkg::S_LOOKUP;
        end
      end
      gbp_pkg::S_LOOKUP: begin
        state_nxt = gbp_pkg::S_UPDATE;
      end
      gbp_pkg::S_UPDATE: begin
        if (fire) begin
          state_nxt = gbp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gbp_pkg::S_CLEAR;
      end
    endcase
  end

  // Gshare index for predicts, queued index for resolves
  assign idx_nxt = is_pred ? (INDEX_BITS'(pc_r) ^ ghr_r) : pend_ridx;
  assign pht_re    = (state_r == gbp_pkg::S_LOOKUP);
  assign pht_raddr = idx_nxt;

  always_comb begin
    pht_we    = 1'b0;
    pht_waddr = idx_r;
    pht_wdata = ctr_trained;
    btb_we      = 1'b0;
    btb_waddr   = pc_r;
    btb_wvalid  = 1'b1;
    btb_wtarget = tgt_r;
    if (clearing) begin
      pht_we      = ((clr_cnt_r >> INDEX_BITS) == '0);
      pht_waddr   = clr_cnt_r[INDEX_BITS-1:0];
      pht_wdata   = gbp_pkg::CTR_INIT;
      btb_we      = ((clr_cnt_r >> gbp_pkg::PC_BITS) == '0);
      btb_waddr   = clr_cnt_r[gbp_pkg::PC_BITS-1:0];
      btb_wvalid  = 1'b0;
      btb_wtarget = '0;
    end else if (fire && !is_pred && !btb_rvalid) begin
      // Install on a resolve miss; counter at the raw PC goes to 0
      btb_we    = 1'b1;
      pht_we    = 1'b1;
      pht_waddr = INDEX_BITS'(pc_r);
      pht_wdata = gbp_pkg::CTR_INIT;
    end else if (train) begin
      pht_we = 1'b1;
    end
  end

  assign pend_ctl.rd_en = accept;
  assign pend_ctl.push  = fire && pred_hit && !pend_sts.full;
  assign pend_ctl.pop   = train;

  assign ghr_nxt = train ? {ghr_r[INDEX_BITS-2:0], up} : ghr_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbp_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      ghr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ghr_r       <= ghr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      pc_r     <= in_branch_pc;
      tgt_r    <= in_target_addr;
      fall_r   <= in_fallthrough_addr;
      actual_r <= in_actual_target;
    end
    if (pht_re) begin
      idx_r <= idx_nxt;
    end
    if (fire) begin
      out_hit_r    <= btb_rvalid;
      out_taken_r  <= taken;
      out_paddr_r  <= paddr;
      out_misp_r   <= train && (pend_rpred != actual_r);
      out_redir_r  <= is_pred ? '0 : actual_r;
      out_status_r <= status;
    end
  end

  gbp_btb u_btb (
    .clk     (clk),
    .we      (btb_we),
    .waddr   (btb_waddr),
    .wvalid  (btb_wvalid),
    .wtarget (btb_wtarget),
    .re      (accept),
    .raddr   (in_branch_pc),
    .rvalid  (btb_rvalid),
    .rtarget (btb_rtarget)
  );

  gbp_pht #(
    .INDEX_BITS (INDEX_BITS)
  ) u_pht (
    .clk   (clk),
    .we    (pht_we),
    .waddr (pht_waddr),
    .wdata (pht_wdata),
    .re    (pht_re),
    .raddr (pht_raddr),
    .rdata (pht_rdata)
  );

  gbp_pend #(
    .INDEX_BITS    (INDEX_BITS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_pend (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pend_ctl),
    .widx  (idx_r),
    .wpred (paddr),
    .ridx  (pend_ridx),
    .rpred (pend_rpred),
    .sts   (pend_sts)
  );

  assign out_valid          = out_valid_r;
  assign out_btb_hit        = out_hit_r;
  assign out_predict_taken  = out_taken_r;
  assign out_predicted_addr = out_paddr_r;
  assign out_mispredict     = out_misp_r;
  assign out_redirect_addr  = out_redir_r;
  assign out_status         = out_status_r;

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == gbp_pkg::S_LOOKUP))
    else $error("accepted item did not move to lookup");

  a_hold_counter_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == gbp_pkg::S_UPDATE) && !fire) |->
      (!pht_re ##1 (state_r == gbp_pkg::S_UPDATE)))
    else $error("counter read lost while waiting for the output register");

  a_push_no_table_write: assert property (@(posedge clk) disable iff (!rst_n)
    pend_ctl.push |-> (!pht_we && !btb_we && !pend_ctl.pop))
    else $error("queue push overlaps a table write");

  a_no_fire_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && (state_r == gbp_pkg::S_UPDATE)) |=>
      (state_r == gbp_pkg::S_UPDATE))
    else $error("update completed while the output register was held");

endmodule
